// ===== design/lr_pkg.sv =====
package lr_pkg;

	// default coordinate width, two's complement
	localparam int COORD_BITS_DEF = 6;

	// controller to datapath
	typedef struct packed {
		logic load;   // take a new segment from the input item
		logic step;   // advance to the next point
	} lr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;   // current point is the final one of the line
	} lr_status_t;

endpackage

// ===== design/lr_in_if.sv =====
interface lr_in_if #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_start;
	logic signed [COORD_BITS-1:0] y_start;
	logic signed [COORD_BITS-1:0] x_end;
	logic signed [COORD_BITS-1:0] y_end;

	modport source (output valid, output x_start, output y_start, output x_end, output y_end,
		input ready);
	modport sink (input valid, input x_start, input y_start, input x_end, input y_end,
		output ready);
endinterface

// ===== design/lr_out_if.sv =====
interface lr_out_if #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic                         last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

// ===== design/lr_ctrl.sv =====
module lr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lr_pkg::lr_status_t status,
	output lr_pkg::lr_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} lr_state_t;

	lr_state_t state_q;
	lr_state_t state_d;
	logic      is_run;
	logic      done;
	logic      accept;

	assign is_run    = (state_q == ST_RUN);
	assign done      = is_run & out_ready & status.last;
	// take the next segment when idle or while the final point leaves
	assign in_ready  = (state_q == ST_IDLE) | done;
	assign accept    = in_valid & in_ready;
	assign out_valid = is_run;

	always_comb begin
		cmd.load = accept;
		cmd.step = is_run & out_ready & ~status.last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (done && !accept) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/lr_dpath.sv =====
module lr_dpath #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lr_pkg::lr_cmd_t              cmd,
	output lr_pkg::lr_status_t           status,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y
);

	localparam int EB = COORD_BITS + 3;   // error term width

	logic signed [COORD_BITS:0]   diff_x;
	logic signed [COORD_BITS:0]   diff_y;
	logic        [COORD_BITS-1:0] dx;
	logic        [COORD_BITS-1:0] dy;
	logic                         x_major;
	logic        [COORD_BITS-1:0] major;
	logic        [COORD_BITS-1:0] minor;
	logic signed [EB-1:0]         grow;
	logic signed [EB-1:0]         grow_major;
	logic signed [EB-1:0]         err_init;

	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;
	logic signed [EB-1:0]         err_q;
	logic signed [EB-1:0]         grow_q;
	logic signed [EB-1:0]         grow_step_q;
	logic        [COORD_BITS-1:0] cnt_q;
	logic                         x_major_q;
	logic                         sx_neg_q;
	logic                         sy_neg_q;
	logic                         diag;
	logic                         step_x;
	logic                         step_y;
	logic signed [COORD_BITS-1:0] inc_x;
	logic signed [COORD_BITS-1:0] inc_y;

	assign diff_x = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
	assign diff_y = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
	// magnitudes fit in COORD_BITS unsigned bits
	assign dx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
	assign dy = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

	assign x_major    = (dx > dy);
	assign major      = x_major ? dx : dy;
	assign minor      = x_major ? dy : dx;
	assign grow       = {2'b00, minor, 1'b0};
	assign grow_major = {2'b00, major, 1'b0};
	assign err_init   = grow - $signed({3'b000, major});

	assign diag   = (err_q > 0);
	assign step_x = x_major_q | diag;
	assign step_y = ~x_major_q | diag;
	assign inc_x  = sx_neg_q ? '1 : COORD_BITS'(1);
	assign inc_y  = sy_neg_q ? '1 : COORD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q        <= '0;
			cy_q        <= '0;
			err_q       <= '0;
			grow_q      <= '0;
			grow_step_q <= '0;
			cnt_q       <= '0;
			x_major_q   <= 1'b0;
			sx_neg_q    <= 1'b0;
			sy_neg_q    <= 1'b0;
		end else if (cmd.load) begin
			cx_q        <= x_start;
			cy_q        <= y_start;
			err_q       <= err_init;
			grow_q      <= grow;
			grow_step_q <= grow - grow_major;
			cnt_q       <= major;
			x_major_q   <= x_major;
			sx_neg_q    <= ~(x_start < x_end);
			sy_neg_q    <= ~(y_start < y_end);
		end else if (cmd.step) begin
			if (step_x) cx_q <= cx_q + inc_x;
			if (step_y) cy_q <= cy_q + inc_y;
			err_q <= err_q + (diag ? grow_step_q : grow_q);
			cnt_q <= cnt_q - COORD_BITS'(1);
		end
	end

	assign status.last = (cnt_q == '0);
	assign point_x     = cx_q;
	assign point_y     = cy_q;

endmodule

// ===== design/line_rasterizer.sv =====
// Bresenham line rasterizer: one input item gives major delta + 1 point items.
// The first point is valid in the cycle after the segment is accepted.
// Throughput: one point per cycle from the point register while the sink is ready,
// and the next segment loads as the final point leaves.
// Reset: arst_n, asynchronous active low, returns the controller to idle with no point pending.
module line_rasterizer #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	lr_in_if.sink   seg,
	lr_out_if.source pt
);

	lr_pkg::lr_cmd_t    cmd;
	lr_pkg::lr_status_t status;

	// Controller: idle / run sequencing and both handshakes.
	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.out_valid (pt.valid),
		.out_ready (pt.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: deltas, error term, current point and remaining count.
	// The current point register is the output register: it holds while
	// the sink stalls and advances only when a point item is taken.
	lr_dpath #(
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.x_start (seg.x_start),
		.y_start (seg.y_start),
		.x_end   (seg.x_end),
		.y_end   (seg.y_end),
		.point_x (pt.point_x),
		.point_y (pt.point_y)
	);

	// Flag the final point of the line.
	assign pt.last_point = status.last;

endmodule
